@@ hdl/bclm_pkg.sv @@
`default_nettype none

package bclm_pkg;

    // Default sizes of the map and of the slot set.
    localparam int MAX_BANKS_DEF = 512;
    localparam int MAX_SLOTS_DEF = 32;

    // Field widths.
    localparam int BANK_W        = 9;
    localparam int STATUS_W      = 3;
    localparam int SLOT_OUT_W    = 5;
    localparam int STAMP_W       = 32;
    localparam int CACHE_SLOTS_W = 6;
    localparam int BANK_COUNT_W  = 10;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_SLOTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_COUNT  = 1'b1;

    localparam logic [CACHE_SLOTS_W-1:0] CACHE_SLOTS_RST = 6'd32;
    localparam logic [BANK_COUNT_W-1:0]  BANK_COUNT_RST  = 10'd512;

    // Map memory: each row holds a group of bank entries.
    localparam int MAP_LANES   = 32;
    localparam int LANE_W      = $clog2(MAP_LANES);
    localparam int MAP_ENTRY_W = 8;
    localparam logic [MAP_ENTRY_W-1:0] MAP_NOT_CACHED = 8'h80;
    localparam logic [MAP_ENTRY_W-1:0] MAP_DIRECT     = 8'h40;

    typedef logic [MAP_LANES-1:0][MAP_ENTRY_W-1:0] map_row_t;

    // Operation codes.
    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_MARK    = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DIRECT = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HIT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MARKED = 3'd4;

    typedef struct packed {
        logic              func;
        logic [BANK_W-1:0] bank;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evicted_valid;
        logic [BANK_W-1:0]     evicted_bank;
    } rsp_t;

endpackage

`default_nettype wire

@@ hdl/bank_cache_lru_mapper.sv @@
// Bank cache mapper: maps ROM bank numbers to cache slots, least recently used first.
// Request channel (req_valid, req_stall, req_data): func selects a bank request or a
// mark as direct; a transaction completes when req_valid is high and req_stall low.
// Result channel (rsp_valid, rsp_stall, rsp_data): one result per request, in order.
// Configuration: cfg_we with cfg_index 0 writes the slot count, 1 the bank count.
// Flow: the block works on one transaction at a time. An out of range request goes
// from the range check straight to the result; direct, hit and mark read one map row
// first. A miss scans the stamps of the slots in use (one stamp memory read per
// cycle), then searches the map rows of the banks in use for the slot's owner (one
// map row read per cycle), clears the owner's entry when a bank is evicted, and
// writes the new map entry and stamp.
// A new request is taken as soon as the previous one has moved to the output register,
// even while that result still waits on rsp_stall; the block then holds the new result
// until the output register is free.
// Reset: a clearing pass, one map row and one stamp per step, sets every map
// entry to not cached and every stamp to zero; req_stall stays high meanwhile, while
// configuration writes are taken as usual.
`default_nettype none

module bank_cache_lru_mapper #(
    parameter int MAX_BANKS = bclm_pkg::MAX_BANKS_DEF,
    parameter int MAX_SLOTS = bclm_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_stall,
    input  wire bclm_pkg::req_t                   req_data,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    output bclm_pkg::rsp_t                        rsp_data,
    input  wire logic                             cfg_we,
    input  wire logic [bclm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bclm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Derived sizes.
    localparam int MAP_ROWS = (MAX_BANKS + bclm_pkg::MAP_LANES - 1) / bclm_pkg::MAP_LANES;
    localparam int ROW_W    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int SLOT_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SCNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int LIM_W    = ($clog2(MAX_BANKS + 1) > bclm_pkg::BANK_COUNT_W)
                              ? $clog2(MAX_BANKS + 1) : bclm_pkg::BANK_COUNT_W;
    localparam int SC_W     = (ROW_W > SLOT_W) ? ROW_W : SLOT_W;
    localparam int CLR_LEN  = (MAP_ROWS > MAX_SLOTS) ? MAP_ROWS : MAX_SLOTS;
    localparam int CLR_W    = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;
    localparam int ROW_BITS = $bits(bclm_pkg::map_row_t);

    // State codes.
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_LOOKUP  = 4'd3;
    localparam logic [3:0] S_SCAN    = 4'd4;
    localparam logic [3:0] S_OWN     = 4'd5;
    localparam logic [3:0] S_EV_RD   = 4'd6;
    localparam logic [3:0] S_EV_WR   = 4'd7;
    localparam logic [3:0] S_FILL_RD = 4'd8;
    localparam logic [3:0] S_FILL_WR = 4'd9;
    localparam logic [3:0] S_RESP    = 4'd10;

    // Control registers.
    logic [3:0]                           state_reg, state_next;
    logic [CLR_W-1:0]                     clr_reg, clr_next;
    logic                                 scan_on_reg, scan_on_next;
    logic                                 pend_reg, pend_next;
    logic                                 rsp_valid_reg, rsp_valid_next;
    logic [bclm_pkg::STAMP_W-1:0]         use_ctr_reg, use_ctr_next;
    logic [bclm_pkg::CACHE_SLOTS_W-1:0]   cache_slots_reg;
    logic [bclm_pkg::BANK_COUNT_W-1:0]    bank_count_reg;

    // Payload registers.
    bclm_pkg::req_t                       req_reg, req_next;
    bclm_pkg::rsp_t                       res_reg, res_next;
    bclm_pkg::rsp_t                       rsp_reg, rsp_next;
    logic [SC_W-1:0]                      scan_reg, scan_next;
    logic [SC_W-1:0]                      pend_idx_reg, pend_idx_next;
    logic [SLOT_W-1:0]                    pick_reg, pick_next;
    logic [bclm_pkg::STAMP_W-1:0]         min_reg, min_next;
    logic [LIM_W-1:0]                     owner_reg, owner_next;
    logic                                 owner_found_reg, owner_found_next;

    // Memory ports.
    logic                                 map_we, map_re;
    logic [ROW_W-1:0]                     map_waddr, map_raddr;
    logic [ROW_BITS-1:0]                  map_wdata, map_rdata;
    bclm_pkg::map_row_t                   map_rd_row, row_wr;
    logic                                 stamp_we, stamp_re;
    logic [SLOT_W-1:0]                    stamp_waddr, stamp_raddr;
    logic [bclm_pkg::STAMP_W-1:0]         stamp_wdata, stamp_rdata;

    // Decoded values.
    logic [SCNT_W-1:0]                    n_slots;
    logic [SLOT_W-1:0]                    slot_last;
    logic [LIM_W-1:0]                     limit, bank_count_ext, bank_ext;
    logic [ROW_W-1:0]                     row_last, bank_row, owner_row;
    logic [bclm_pkg::LANE_W-1:0]          bank_lane, owner_lane;
    logic                                 in_range;
    logic [bclm_pkg::MAP_ENTRY_W-1:0]     entry;
    logic [SLOT_W-1:0]                    hit_slot;
    logic [bclm_pkg::STAMP_W-1:0]         ctr_inc;
    logic                                 row_hit;
    logic [LIM_W-1:0]                     row_owner;

    bclm_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (MAP_ROWS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (map_we),
        .wr_addr (map_waddr),
        .wr_data (map_wdata),
        .rd_en   (map_re),
        .rd_addr (map_raddr),
        .rd_data (map_rdata)
    );

    bclm_ram #(
        .WIDTH (bclm_pkg::STAMP_W),
        .DEPTH (MAX_SLOTS)
    ) u_stamp_ram (
        .clk     (clk),
        .wr_en   (stamp_we),
        .wr_addr (stamp_waddr),
        .wr_data (stamp_wdata),
        .rd_en   (stamp_re),
        .rd_addr (stamp_raddr),
        .rd_data (stamp_rdata)
    );

    assign map_rd_row = bclm_pkg::map_row_t'(map_rdata);

    // Effective slot count: clamped to the slot memory, zero acts as one.
    always_comb
    begin
        if (cache_slots_reg > MAX_SLOTS)
        begin
            n_slots = SCNT_W'(MAX_SLOTS);
        end
        else if (cache_slots_reg == '0)
        begin
            n_slots = SCNT_W'(1);
        end
        else
        begin
            n_slots = SCNT_W'(cache_slots_reg);
        end
    end

    assign slot_last = SLOT_W'(n_slots - SCNT_W'(1));

    // Effective bank limit and the row and lane of the banks in play.
    assign bank_count_ext = LIM_W'(bank_count_reg);
    assign limit      = (bank_count_ext > LIM_W'(MAX_BANKS)) ? LIM_W'(MAX_BANKS)
                                                             : bank_count_ext;
    assign row_last   = ROW_W'((limit - LIM_W'(1)) >> bclm_pkg::LANE_W);
    assign bank_ext   = LIM_W'(req_reg.bank);
    assign in_range   = bank_ext < limit;
    assign bank_row   = ROW_W'(bank_ext >> bclm_pkg::LANE_W);
    assign bank_lane  = req_reg.bank[bclm_pkg::LANE_W-1:0];
    assign owner_row  = ROW_W'(owner_reg >> bclm_pkg::LANE_W);
    assign owner_lane = owner_reg[bclm_pkg::LANE_W-1:0];
    assign entry      = map_rd_row[bank_lane];
    assign hit_slot   = SLOT_W'(entry);
    assign ctr_inc    = (use_ctr_reg != '1) ? use_ctr_reg + 1'b1 : use_ctr_reg;

    // Highest bank in the returned map row, other than bank 0, that holds the picked slot.
    always_comb
    begin
        logic [LIM_W-1:0] idx;
        row_hit   = 1'b0;
        row_owner = '0;
        for (int k = 0; k < bclm_pkg::MAP_LANES; k++)
        begin
            idx = (LIM_W'(pend_idx_reg) << bclm_pkg::LANE_W) | LIM_W'(k);
            if (idx != '0 && idx < limit
                && map_rd_row[k] == bclm_pkg::MAP_ENTRY_W'(pick_reg))
            begin
                row_hit   = 1'b1;
                row_owner = idx;
            end
        end
    end

    // Sequencer: read, modify and write back the map and stamp memories.
    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        scan_on_next     = scan_on_reg;
        pend_next        = 1'b0;
        pend_idx_next    = pend_idx_reg;
        scan_next        = scan_reg;
        pick_next        = pick_reg;
        min_next         = min_reg;
        owner_next       = owner_reg;
        owner_found_next = owner_found_reg;
        use_ctr_next     = use_ctr_reg;
        req_next         = req_reg;
        res_next         = res_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;

        row_wr           = map_rd_row;
        map_we           = 1'b0;
        map_waddr        = bank_row;
        map_wdata        = ROW_BITS'(row_wr);
        map_re           = 1'b0;
        map_raddr        = bank_row;
        stamp_we         = 1'b0;
        stamp_waddr      = pick_reg;
        stamp_wdata      = use_ctr_reg;
        stamp_re         = 1'b0;
        stamp_raddr      = SLOT_W'(scan_reg);

        unique case (state_reg)
            S_CLEAR:
            begin
                // One map row and one stamp per cycle.
                map_we      = clr_reg < MAP_ROWS;
                map_waddr   = ROW_W'(clr_reg);
                map_wdata   = {bclm_pkg::MAP_LANES{bclm_pkg::MAP_NOT_CACHED}};
                stamp_we    = clr_reg < MAX_SLOTS;
                stamp_waddr = SLOT_W'(clr_reg);
                stamp_wdata = '0;
                if (clr_reg == CLR_W'(CLR_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_data;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (!in_range)
                begin
                    res_next.status        = bclm_pkg::ST_RANGE;
                    res_next.slot          = '0;
                    res_next.evicted_valid = 1'b0;
                    res_next.evicted_bank  = '0;
                    state_next             = S_RESP;
                end
                else
                begin
                    map_re     = 1'b1;
                    state_next = S_LOOKUP;
                end
            end

            S_LOOKUP:
            begin
                res_next.slot          = '0;
                res_next.evicted_valid = 1'b0;
                res_next.evicted_bank  = '0;
                state_next             = S_RESP;
                if (req_reg.func == bclm_pkg::FUNC_MARK)
                begin
                    row_wr[bank_lane] = bclm_pkg::MAP_DIRECT;
                    map_we            = 1'b1;
                    map_wdata         = ROW_BITS'(row_wr);
                    res_next.status   = bclm_pkg::ST_MARKED;
                end
                else if ((entry & bclm_pkg::MAP_DIRECT) != '0)
                begin
                    res_next.status = bclm_pkg::ST_DIRECT;
                end
                else if ((entry & bclm_pkg::MAP_NOT_CACHED) != '0)
                begin
                    // Miss: scan the slot stamps for the oldest.
                    scan_next    = '0;
                    scan_on_next = 1'b1;
                    state_next   = S_SCAN;
                end
                else
                begin
                    stamp_we        = 1'b1;
                    stamp_waddr     = hit_slot;
                    use_ctr_next    = ctr_inc;
                    res_next.status = bclm_pkg::ST_HIT;
                    res_next.slot   = bclm_pkg::SLOT_OUT_W'(hit_slot);
                end
            end

            S_SCAN:
            begin
                if (scan_on_reg)
                begin
                    stamp_re      = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg;
                    if (scan_reg == SC_W'(slot_last))
                    begin
                        scan_on_next = 1'b0;
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
                if (pend_reg)
                begin
                    // The first smallest stamp wins.
                    if (pend_idx_reg == '0 || stamp_rdata < min_reg)
                    begin
                        pick_next = SLOT_W'(pend_idx_reg);
                        min_next  = stamp_rdata;
                    end
                    if (!scan_on_reg)
                    begin
                        scan_next        = '0;
                        scan_on_next     = 1'b1;
                        owner_next       = '0;
                        owner_found_next = 1'b0;
                        state_next       = S_OWN;
                    end
                end
            end

            S_OWN:
            begin
                if (scan_on_reg)
                begin
                    map_re        = 1'b1;
                    map_raddr     = ROW_W'(scan_reg);
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg;
                    if (scan_reg == SC_W'(row_last))
                    begin
                        scan_on_next = 1'b0;
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
                if (pend_reg)
                begin
                    if (row_hit)
                    begin
                        owner_next       = row_owner;
                        owner_found_next = 1'b1;
                    end
                    if (!scan_on_reg)
                    begin
                        state_next = (row_hit || owner_found_reg) ? S_EV_RD : S_FILL_RD;
                    end
                end
            end

            S_EV_RD:
            begin
                map_re     = 1'b1;
                map_raddr  = owner_row;
                state_next = S_EV_WR;
            end

            S_EV_WR:
            begin
                row_wr[owner_lane] = bclm_pkg::MAP_NOT_CACHED;
                map_we             = 1'b1;
                map_waddr          = owner_row;
                map_wdata          = ROW_BITS'(row_wr);
                state_next         = S_FILL_RD;
            end

            S_FILL_RD:
            begin
                map_re     = 1'b1;
                state_next = S_FILL_WR;
            end

            S_FILL_WR:
            begin
                row_wr[bank_lane] = bclm_pkg::MAP_ENTRY_W'(pick_reg);
                map_we            = 1'b1;
                map_wdata         = ROW_BITS'(row_wr);
                stamp_we          = 1'b1;
                use_ctr_next      = ctr_inc;
                res_next.status        = bclm_pkg::ST_MISS;
                res_next.slot          = bclm_pkg::SLOT_OUT_W'(pick_reg);
                res_next.evicted_valid = owner_found_reg;
                res_next.evicted_bank  = bclm_pkg::BANK_W'(owner_reg);
                state_next        = S_RESP;
            end

            S_RESP:
            begin
                // Hand the result over once the output register is free.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            scan_on_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            use_ctr_reg   <= bclm_pkg::STAMP_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            scan_on_reg   <= scan_on_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            use_ctr_reg   <= use_ctr_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_slots_reg <= bclm_pkg::CACHE_SLOTS_RST;
            bank_count_reg  <= bclm_pkg::BANK_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bclm_pkg::CFG_CACHE_SLOTS:
                    cache_slots_reg <= cfg_data[bclm_pkg::CACHE_SLOTS_W-1:0];
                bclm_pkg::CFG_BANK_COUNT:
                    bank_count_reg <= cfg_data[bclm_pkg::BANK_COUNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        res_reg         <= res_next;
        rsp_reg         <= rsp_next;
        scan_reg        <= scan_next;
        pend_idx_reg    <= pend_idx_next;
        pick_reg        <= pick_next;
        min_reg         <= min_next;
        owner_reg       <= owner_next;
        owner_found_reg <= owner_found_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Only a miss may report an eviction.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.evicted_valid |-> rsp_data.status == bclm_pkg::ST_MISS)
        else $error("eviction reported on a transaction that was not a miss");

    // Results other than hit or miss carry no slot and no eviction.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != bclm_pkg::ST_HIT
        && rsp_data.status != bclm_pkg::ST_MISS
        |-> rsp_data.slot == '0 && !rsp_data.evicted_valid && rsp_data.evicted_bank == '0)
        else $error("slot or eviction fields set on a non-cache result");

    // A new result is loaded only into a free or draining output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result was overwritten or dropped");

    // The use counter only moves when a slot is stamped outside the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        use_ctr_reg != use_ctr_next |-> stamp_we && state_reg != S_CLEAR)
        else $error("use counter changed without a stamp write");

endmodule

`default_nettype wire

@@ hdl/bclm_ram.sv @@
`default_nettype none

module bclm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
